FILE: rtl/jlt_pkg.sv
// ----------------------------------------------------------------------------
// jlt_pkg
// constants, types and helpers shared by the joint transform pipeline
// ----------------------------------------------------------------------------
package jlt_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic signed [31:0] PHASE_SCALE = 32'sd341782638;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;
    localparam logic JK_ROTARY = 1'b0;
    localparam logic JK_SLIDING = 1'b1;

    typedef struct packed {
        logic                joint_kind;
        logic signed [31:0]  position_value;
        logic signed [15:0]  axis_x;
        logic signed [15:0]  axis_y;
        logic signed [15:0]  axis_z;
        logic signed [31:0]  offset_x;
        logic signed [31:0]  offset_y;
        logic signed [31:0]  offset_z;
        logic signed [15:0]  origin_qx;
        logic signed [15:0]  origin_qy;
        logic signed [15:0]  origin_qz;
        logic signed [15:0]  origin_qw;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0]  rot_x;
        logic signed [15:0]  rot_y;
        logic signed [15:0]  rot_z;
        logic signed [15:0]  rot_w;
        logic signed [31:0]  shift_x;
        logic signed [31:0]  shift_y;
        logic signed [31:0]  shift_z;
        logic                rotation_is_identity;
    } t_out_beat;

    // values carried along the cordic chain
    typedef struct packed {
        logic               vld;
        t_in_beat           beat;
        logic [1:0]         quad;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
    } t_cell;

    function automatic logic signed [31:0] atan_turn(input int idx);
        logic signed [31:0] t;
        case (idx)
            0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
            3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
            6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
            9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
            12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
            15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
            18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
            21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd32767) r = 16'sd32767;
        else if (v < -36'sd32768) r = -16'sd32768;
        else r = v[15:0];
        return r;
    endfunction

    // q2.28 sum to q1.14, half up, saturated
    function automatic logic signed [15:0] q14_of_q28(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + 36'sd8192) >>> 14;
        return sat16(t);
    endfunction

endpackage

FILE: rtl/jlt_stream_if.sv
// ----------------------------------------------------------------------------
// jlt_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface jlt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/joint_local_transform.sv
// ----------------------------------------------------------------------------
// joint_local_transform
// local transform of one kinematic joint, quaternion plus translation
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one joint per beat (kind, position, axis, offset, origin
//   quaternion); o_out carries its rotation, translation and identity flag.
//   a beat is taken when valid and ready are both high.
//   throughput: one joint per cycle while the receiver does not stall o_out.
//   pipeline, from input beat to output beat: one
//   phase stage, one cell per cordic micro-rotation, then four stages:
//   quadrant fix with axis products, rounding with slide sums, hamilton
//   products, and the output register.
//   the whole pipeline advances together; when the receiver stalls with a
//   result waiting, the chain holds and i_in ready drops, so nothing is lost.
//   ready stays high while the output register is empty or being drained.
//   reset (i_rst_n low, synchronous) empties the pipeline; no other state.
// ----------------------------------------------------------------------------
module joint_local_transform (
    input  logic i_clk,
    input  logic i_rst_n,
    jlt_stream_if.sink   i_in,
    jlt_stream_if.source o_out
);
    import jlt_pkg::*;

    logic       en;
    t_cell      chain [CORDIC_STEPS+1];
    t_cell      r_ph;
    t_cell      n_ph;
    logic signed [63:0] prod;
    logic [63:0] u;
    logic [31:0] p;
    logic       out_vld;

    assign en = !out_vld || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        prod = 64'(i_in.payload.position_value) * 64'(PHASE_SCALE);
        u = 64'(prod) + 64'd32768;
        p = u[47:16] + 32'h20000000;
        n_ph.vld = i_in.valid;
        n_ph.beat = i_in.payload;
        n_ph.quad = p[31:30];
        n_ph.x = CORDIC_START;
        n_ph.y = '0;
        n_ph.z = 32'({2'b00, p[29:0]}) - 32'sh20000000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph.vld <= 1'b0;
        end else if (en) begin
            r_ph.vld <= n_ph.vld;
        end
        if (en) begin
            r_ph.beat <= n_ph.beat;
            r_ph.quad <= n_ph.quad;
            r_ph.x <= n_ph.x;
            r_ph.y <= n_ph.y;
            r_ph.z <= n_ph.z;
        end
    end

    assign chain[0] = r_ph;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        jlt_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_step (STEP_W'(g)),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    jlt_compose u_compose (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_cell (chain[CORDIC_STEPS]),
        .o_vld  (out_vld),
        .o_beat (o_out.payload)
    );

    assign o_out.valid = out_vld;
endmodule

FILE: rtl/jlt_cordic_cell.sv
// ----------------------------------------------------------------------------
// jlt_cordic_cell
// one rotation-mode cordic micro-rotation with its pipeline register
// ----------------------------------------------------------------------------
module jlt_cordic_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic [jlt_pkg::STEP_W-1:0] i_step,
    input  jlt_pkg::t_cell           i_cell,
    output jlt_pkg::t_cell           o_cell
);
    import jlt_pkg::*;

    t_cell r_cell;
    t_cell n_cell;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [31:0] at;

    always_comb begin
        dx = i_cell.y >>> i_step;
        dy = i_cell.x >>> i_step;
        at = atan_turn(int'(i_step));
        n_cell = i_cell;
        if (!i_cell.z[31]) begin
            n_cell.x = i_cell.x - dx;
            n_cell.y = i_cell.y + dy;
            n_cell.z = i_cell.z - at;
        end else begin
            n_cell.x = i_cell.x + dx;
            n_cell.y = i_cell.y - dy;
            n_cell.z = i_cell.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= i_cell.vld;
        end
        if (i_en) begin
            r_cell.beat <= n_cell.beat;
            r_cell.quad <= n_cell.quad;
            r_cell.x    <= n_cell.x;
            r_cell.y    <= n_cell.y;
            r_cell.z    <= n_cell.z;
        end
    end

    assign o_cell = r_cell;
endmodule

FILE: rtl/jlt_compose.sv
// ----------------------------------------------------------------------------
// jlt_compose
// quadrant fix, joint quaternion, origin product and slide translation
// ----------------------------------------------------------------------------
module jlt_compose (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  jlt_pkg::t_cell      i_cell,
    output logic                o_vld,
    output jlt_pkg::t_out_beat  o_beat
);
    import jlt_pkg::*;

    // stage a: sin/cos and axis products
    logic               r_a_vld;
    t_in_beat           r_a_beat;
    logic signed [15:0] r_a_c;
    logic signed [31:0] r_a_p [3];
    logic signed [47:0] r_a_sl [3];
    // stage b: joint quaternion and slide sums
    logic               r_b_vld;
    t_in_beat           r_b_beat;
    logic signed [15:0] r_b_j [4];
    logic signed [31:0] r_b_sh [3];
    // stage c: hamilton products
    logic               r_c_vld;
    t_in_beat           r_c_beat;
    logic signed [15:0] r_c_j [4];
    logic signed [31:0] r_c_sh [3];
    logic signed [31:0] r_c_m [16];
    t_out_beat          r_out;
    logic               r_out_vld;

    logic signed [15:0] n_c0, n_s0, n_c, n_s;
    logic signed [35:0] xr, yr;
    logic signed [15:0] ax [3];
    logic signed [31:0] off [3];
    logic signed [15:0] oq [4];
    logic signed [15:0] n_j [4];
    logic signed [31:0] n_sh [3];
    logic signed [47:0] sl;
    logic signed [33:0] ssum;
    logic signed [35:0] hs [4];
    t_out_beat          n_out;

    always_comb begin
        xr = (36'(i_cell.x) + 36'sd32768) >>> 16;
        yr = (36'(i_cell.y) + 36'sd32768) >>> 16;
        n_c0 = sat16(xr);
        n_s0 = sat16(yr);
        case (i_cell.quad)
            2'd1: begin
                n_c = sat16(-36'(n_s0)); n_s = n_c0;
            end
            2'd2: begin
                n_c = sat16(-36'(n_c0)); n_s = sat16(-36'(n_s0));
            end
            2'd3: begin
                n_c = n_s0; n_s = sat16(-36'(n_c0));
            end
            default: begin
                n_c = n_c0; n_s = n_s0;
            end
        endcase
        ax[0] = i_cell.beat.axis_x;
        ax[1] = i_cell.beat.axis_y;
        ax[2] = i_cell.beat.axis_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_beat <= i_cell.beat;
            r_a_c <= n_c;
            for (int k = 0; k < 3; k++) begin
                r_a_p[k]  <= ax[k] * n_s;
                r_a_sl[k] <= ax[k] * i_cell.beat.position_value;
            end
        end
    end

    always_comb begin
        off[0] = r_a_beat.offset_x;
        off[1] = r_a_beat.offset_y;
        off[2] = r_a_beat.offset_z;
        for (int k = 0; k < 3; k++) begin
            n_j[k] = q14_of_q28(36'(r_a_p[k]));
            sl = (r_a_sl[k] + 48'sd8192) >>> 14;
            ssum = 34'(off[k]) + 34'(sl[33:0]);
            if (sl > 48'sd4294967295 || ssum > 34'sd2147483647) n_sh[k] = 32'h7FFFFFFF;
            else if (sl < -48'sd4294967296 || ssum < -34'sd2147483648)
                n_sh[k] = 32'h80000000;
            else n_sh[k] = ssum[31:0];
        end
        n_j[3] = r_a_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_beat <= r_a_beat;
            r_b_j <= n_j;
            r_b_sh <= n_sh;
        end
    end

    always_comb begin
        oq[0] = r_b_beat.origin_qx;
        oq[1] = r_b_beat.origin_qy;
        oq[2] = r_b_beat.origin_qz;
        oq[3] = r_b_beat.origin_qw;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_beat <= r_b_beat;
            r_c_j <= r_b_j;
            r_c_sh <= r_b_sh;
            for (int a = 0; a < 4; a++) begin
                for (int b = 0; b < 4; b++) begin
                    r_c_m[a*4+b] <= oq[a] * r_b_j[b];
                end
            end
        end
    end

    // m[a*4+b] = o[a]*j[b]
    always_comb begin
        hs[0] = 36'(r_c_m[12]) + 36'(r_c_m[3]) + 36'(r_c_m[6]) - 36'(r_c_m[9]);
        hs[1] = 36'(r_c_m[13]) - 36'(r_c_m[2]) + 36'(r_c_m[7]) + 36'(r_c_m[8]);
        hs[2] = 36'(r_c_m[14]) + 36'(r_c_m[1]) - 36'(r_c_m[4]) + 36'(r_c_m[11]);
        hs[3] = 36'(r_c_m[15]) - 36'(r_c_m[0]) - 36'(r_c_m[5]) - 36'(r_c_m[10]);
        if (r_c_beat.joint_kind == JK_SLIDING) begin
            n_out.rot_x = '0;
            n_out.rot_y = '0;
            n_out.rot_z = '0;
            n_out.rot_w = Q14_ONE;
            n_out.shift_x = r_c_sh[0];
            n_out.shift_y = r_c_sh[1];
            n_out.shift_z = r_c_sh[2];
            n_out.rotation_is_identity = 1'b1;
        end else begin
            if (r_c_beat.origin_qw == Q14_ONE) begin
                n_out.rot_x = r_c_j[0];
                n_out.rot_y = r_c_j[1];
                n_out.rot_z = r_c_j[2];
                n_out.rot_w = r_c_j[3];
            end else begin
                n_out.rot_x = q14_of_q28(hs[0]);
                n_out.rot_y = q14_of_q28(hs[1]);
                n_out.rot_z = q14_of_q28(hs[2]);
                n_out.rot_w = q14_of_q28(hs[3]);
            end
            n_out.shift_x = r_c_beat.offset_x;
            n_out.shift_y = r_c_beat.offset_y;
            n_out.shift_z = r_c_beat.offset_z;
            n_out.rotation_is_identity = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_cell.vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_out_vld <= r_c_vld;
        end
        if (i_en) r_out <= n_out;
    end

    assign o_vld = r_out_vld;
    assign o_beat = r_out;
endmodule
